### hdl/ggc_pkg.sv
// Shared constants, payload types, state codes and helper functions for the graph colourer.
package ggc_pkg;

  localparam int NUM_TYPES         = 5;
  localparam int ELEMENTS_PER_TYPE = 4096;
  localparam int MAX_COLORS        = 16;

  localparam int TABLE_SIZE = NUM_TYPES * ELEMENTS_PER_TYPE;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int ENTRY_W    = 5;

  localparam logic [ENTRY_W-1:0] UNCOLORED = '1;

  typedef struct packed {
    logic [2:0]  element_type;
    logic [11:0] element_index;
    logic [2:0]  neighbor_type;
    logic [11:0] neighbor_index;
    logic        has_neighbor;
    logic        last;
  } ggc_item_t;

  typedef struct packed {
    logic [2:0]  out_type;
    logic [11:0] out_index;
    logic [3:0]  assigned_color;
  } ggc_result_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ggc_state_t;

  function automatic logic in_range(input logic [2:0] typ, input logic [11:0] idx);
    return (32'(typ) < NUM_TYPES) && (32'(idx) < ELEMENTS_PER_TYPE);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [2:0] typ,
                                                input logic [11:0] idx);
    return ADDR_W'(32'(typ) * ELEMENTS_PER_TYPE + 32'(idx));
  endfunction

  // Lowest free colour below the overflow colour, else the overflow colour.
  function automatic logic [ENTRY_W-1:0] first_fit(input logic [MAX_COLORS-1:0] used);
    logic [ENTRY_W-1:0] c;
    c = ENTRY_W'(MAX_COLORS - 1);
    for (int i = MAX_COLORS - 2; i >= 0; i--) begin
      if (!used[i]) c = ENTRY_W'(i);
    end
    return c;
  endfunction

endpackage

### hdl/ggc_if.sv
// Valid/ready channel interfaces for colouring requests and results.
interface ggc_item_if;
  logic                valid;
  logic                ready;
  ggc_pkg::ggc_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ggc_result_if;
  logic                 valid;
  logic                 ready;
  ggc_pkg::ggc_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ggc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### hdl/greedy_graph_coloring.sv
// Top level of the first-fit greedy graph colourer with its colour table in RAM.
//
// Each request carries the element being coloured and at most one neighbour; the neighbour's
// colour is read from the colour table RAM when the request is taken and marked in the
// used-colour set in the request stage. A request marked last picks the lowest free colour
// (or the shared overflow colour), writes it back and registers its result for output.
// One request is taken per cycle; the rate is set by the single read port of the colour table,
// with a write from the preceding request forwarded to a read of the same entry. A result that
// is not taken holds the block only when the next last request needs the output register.
// After reset the table is cleared to uncolored, one entry a cycle, across all
// NUM_TYPES * ELEMENTS_PER_TYPE entries (20480); no request is taken during that pass.
module greedy_graph_coloring (
  input  logic         clk,
  input  logic         rst,
  ggc_item_if.sink     items,
  ggc_result_if.source results
);
  import ggc_pkg::*;

  ggc_state_t state, state_next;
  logic       clearing;

  logic [ADDR_W-1:0]  clr_addr;
  logic               clr_last;

  logic               b_valid;
  ggc_item_t          b_item;
  logic               b_nb_ok;
  logic               b_fwd_hit;
  logic [ENTRY_W-1:0] b_fwd_color;

  logic [MAX_COLORS-1:0] used;
  logic [MAX_COLORS-1:0] used_eff;
  logic [MAX_COLORS-1:0] mark;

  logic        res_valid;
  ggc_result_t res;

  logic               stall_b, accept, fire, b_wr;
  logic [ADDR_W-1:0]  rd_addr, elem_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data, nb_color, color, wr_data;
  logic               we;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  assign clr_last = clr_addr == ADDR_W'(TABLE_SIZE - 1);

  assign stall_b      = b_valid && b_item.last && res_valid && !results.ready;
  assign items.ready  = !clearing && !stall_b;
  assign accept       = items.valid && items.ready;
  assign fire         = b_valid && !stall_b;

  assign rd_addr   = slot_of(items.data.neighbor_type, items.data.neighbor_index);
  assign elem_addr = slot_of(b_item.element_type, b_item.element_index);

  assign nb_color = b_fwd_hit ? b_fwd_color : rd_data;

  always_comb begin
    for (int i = 0; i < MAX_COLORS; i++) begin
      mark[i] = b_nb_ok && (nb_color == ENTRY_W'(i));
    end
  end

  assign used_eff = used | mark;
  assign color    = first_fit(used_eff);

  assign b_wr    = fire && b_item.last && in_range(b_item.element_type, b_item.element_index);
  assign we      = clearing || b_wr;
  assign wr_addr = clearing ? clr_addr : elem_addr;
  assign wr_data = clearing ? UNCOLORED : color;

  ggc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Request stage: capture the request and any write that races its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item      <= items.data;
      b_nb_ok     <= items.data.has_neighbor &&
                     in_range(items.data.neighbor_type, items.data.neighbor_index);
      b_fwd_hit   <= b_wr && (elem_addr == rd_addr);
      b_fwd_color <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (fire) begin
      used <= b_item.last ? '0 : used_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && b_item.last) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && b_item.last) begin
      res.out_type       <= b_item.element_type;
      res.out_index      <= b_item.element_index;
      res.assigned_color <= color[3:0];
    end
  end

  assign results.valid = res_valid;
  assign results.data  = res;

endmodule

### tb/ggc_color_checker.sv
// Checker for the graph colourer: predicts each element's colour and compares the results.
module ggc_color_checker (
  input  logic   clk,
  input  logic   rst,
  ggc_item_if    items,
  ggc_result_if  results,
  output int     errors,
  output int     outstanding
);
  import ggc_pkg::*;

  localparam int NO_SLOT = -1;

  logic [ENTRY_W-1:0]    colour_mem [TABLE_SIZE];
  logic [MAX_COLORS-1:0] taken_colours;
  ggc_result_t           colourings_due [$];
  int                    err_count = 0;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic int table_slot(input logic [2:0] typ, input logic [11:0] idx);
    if (int'(typ) >= NUM_TYPES || int'(idx) >= ELEMENTS_PER_TYPE) return NO_SLOT;
    return int'(typ) * ELEMENTS_PER_TYPE + int'(idx);
  endfunction

  // Lowest colour below the overflow colour not yet taken by a neighbour.
  function automatic logic [3:0] lowest_free_colour(input logic [MAX_COLORS-1:0] taken);
    for (int c = 0; c < MAX_COLORS - 1; c++) begin
      if (!taken[c]) return 4'(c);
    end
    return 4'(MAX_COLORS - 1);
  endfunction

  always @(posedge clk) begin
    ggc_item_t          req;
    ggc_result_t        fresh;
    ggc_result_t        oldest;
    ggc_result_t        got;
    int                 slot;
    logic [ENTRY_W-1:0] nb_colour;

    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) colour_mem[i] = UNCOLORED;
      taken_colours = '0;
      colourings_due.delete();
    end else begin
      if (items.valid && items.ready) begin
        req = items.data;
        if (req.has_neighbor) begin
          slot = table_slot(req.neighbor_type, req.neighbor_index);
          if (slot != NO_SLOT) begin
            nb_colour = colour_mem[slot];
            if (nb_colour != UNCOLORED && int'(nb_colour) < MAX_COLORS)
              taken_colours[nb_colour[3:0]] = 1'b1;
          end
        end
        if (req.last) begin
          fresh.out_type       = req.element_type;
          fresh.out_index      = req.element_index;
          fresh.assigned_color = lowest_free_colour(taken_colours);
          slot = table_slot(req.element_type, req.element_index);
          if (slot != NO_SLOT) colour_mem[slot] = ENTRY_W'(fresh.assigned_color);
          taken_colours = '0;
          colourings_due.push_back(fresh);
        end
      end

      if (results.valid && results.ready) begin
        got = results.data;
        if (colourings_due.size() == 0) begin
          $error("unexpected result: out_type %0d out_index %0d assigned_color %0d",
                 got.out_type, got.out_index, got.assigned_color);
          err_count++;
        end else begin
          oldest = colourings_due.pop_front();
          if (got.out_type !== oldest.out_type) begin
            $error("out_type: expected %0d, got %0d", oldest.out_type, got.out_type);
            err_count++;
          end
          if (got.out_index !== oldest.out_index) begin
            $error("out_index: expected %0d, got %0d", oldest.out_index, got.out_index);
            err_count++;
          end
          if (got.assigned_color !== oldest.assigned_color) begin
            $error("assigned_color: expected %0d, got %0d",
                   oldest.assigned_color, got.assigned_color);
            err_count++;
          end
        end
      end
    end
    errors      <= err_count;
    outstanding <= colourings_due.size();
  end

endmodule

### tb/tb_greedy_graph_coloring.sv
// Testbench top for the greedy graph colourer: clock, reset, request stimulus and verdict.
module tb_greedy_graph_coloring;
  import ggc_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int WATCHDOG    = 8000000;
  localparam int HOT_SPAN    = 15;
  localparam int DRAIN_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   sent      = 0;
  logic [11:0] hot_base = '0;

  ggc_item_if   items ();
  ggc_result_if results ();

  greedy_graph_coloring dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  ggc_color_checker color_check (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .errors      (mismatches),
    .outstanding (pending)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #WATCHDOG;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ggc_item_t make_req(input logic [2:0] et, input logic [11:0] ei,
                                         input logic [2:0] nt, input logic [11:0] ni,
                                         input logic has, input logic last);
    ggc_item_t req;
    req.element_type   = et;
    req.element_index  = ei;
    req.neighbor_type  = nt;
    req.neighbor_index = ni;
    req.has_neighbor   = has;
    req.last           = last;
    return req;
  endfunction

  // Hold the request until it is taken; idle beforehand at the phase's rate.
  task automatic send_req(input ggc_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.data  <= req;
    do @(posedge clk); while (!items.ready);
    sent++;
  endtask

  // Mostly a small window of live elements, so neighbours tend to be coloured.
  task automatic pick_node(output logic [2:0] t, output logic [11:0] i);
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      t = 3'($urandom_range(NUM_TYPES - 1));
      i = hot_base + 12'($urandom_range(HOT_SPAN));
    end else if (r < 92) begin
      t = 3'($urandom_range(NUM_TYPES - 1));
      i = 12'($urandom);
    end else begin
      t = 3'($urandom);
      i = 12'($urandom);
    end
  endtask

  // Element k lists elements 0..k-1 as neighbours: colours climb to the overflow colour.
  task automatic send_ladder();
    logic [2:0]  t;
    logic [11:0] base;
    t    = 3'($urandom_range(NUM_TYPES - 1));
    base = 12'($urandom);
    for (int k = 0; k <= MAX_COLORS; k++) begin
      if (k == 0) send_req(make_req(t, base, t, base, 1'b0, 1'b1));
      else begin
        for (int j = 0; j < k; j++)
          send_req(make_req(t, base + 12'(k), t, base + 12'(j), 1'b1, j == k - 1));
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_items);
    int          start;
    int          r;
    int          n_nb;
    logic [2:0]  et;
    logic [11:0] ei;
    logic [2:0]  nt;
    logic [11:0] ni;
    idle_pct  = idle;
    stall_pct <= stall;
    hot_base  = 12'($urandom);
    start     = sent;
    send_ladder();
    while (sent - start < n_items) begin
      r = $urandom_range(999);
      if (r < 4) send_ladder();
      else if (r < 900) begin
        pick_node(et, ei);
        n_nb = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
        if (n_nb == 0) begin
          pick_node(nt, ni);
          send_req(make_req(et, ei, nt, ni, 1'b0, 1'b1));
        end else begin
          for (int j = 0; j < n_nb; j++) begin
            pick_node(nt, ni);
            send_req(make_req(et, ei, nt, ni, $urandom_range(9) != 0, j == n_nb - 1));
          end
        end
      end else begin
        send_req(make_req(3'($urandom), 12'($urandom), 3'($urandom), 12'($urandom),
                          1'($urandom), $urandom_range(9) < 3));
      end
    end
    // Drop valid and hold off until every colouring has come back.
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    int waited;
    rst           = 1'b1;
    items.valid   = 1'b0;
    items.data    = '0;
    results.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the fields and the corner cases.
    send_req(make_req(3'd0, 12'd0, 3'd7, 12'hFFF, 1'b0, 1'b1));
    send_req(make_req(3'd4, 12'hFFF, 3'd0, 12'd0, 1'b1, 1'b1));
    send_req(make_req(3'd4, 12'hFFE, 3'd4, 12'hFFF, 1'b1, 1'b0));
    send_req(make_req(3'd4, 12'hFFE, 3'd0, 12'd0, 1'b1, 1'b1));
    send_req(make_req(3'd7, 12'hFFF, 3'd0, 12'd0, 1'b1, 1'b1));
    send_req(make_req(3'd5, 12'd0, 3'd4, 12'hFFE, 1'b1, 1'b1));
    send_req(make_req(3'd0, 12'd1, 3'd7, 12'hFFF, 1'b1, 1'b1));
    send_req(make_req(3'd0, 12'd2, 3'd5, 12'd0, 1'b1, 1'b1));
    send_req(make_req(3'd1, 12'd5, 3'd0, 12'd0, 1'b0, 1'b1));
    send_req(make_req(3'd2, 12'd7, 3'd3, 12'hBB8, 1'b1, 1'b1));
    send_req(make_req(3'd4, 12'hFFF, 3'd4, 12'hFFF, 1'b1, 1'b1));
    send_req(make_req(3'd0, 12'd3, 3'd4, 12'hFFF, 1'b1, 1'b1));
    send_req(make_req(3'd1, 12'd1, 3'd0, 12'd0, 1'b1, 1'b0));
    send_req(make_req(3'd1, 12'd1, 3'd0, 12'd3, 1'b1, 1'b0));
    send_req(make_req(3'd1, 12'd1, 3'd0, 12'd0, 1'b1, 1'b0));
    send_req(make_req(3'd1, 12'd1, 3'd6, 12'h555, 1'b0, 1'b1));
    send_req(make_req(3'd3, 12'hAAA, 3'd4, 12'hFFE, 1'b1, 1'b0));
    send_req(make_req(3'd3, 12'hAAA, 3'd1, 12'd1, 1'b1, 1'b0));
    send_req(make_req(3'd3, 12'hAAA, 3'd0, 12'd0, 1'b1, 1'b1));
    send_req(make_req(3'd3, 12'h555, 3'd3, 12'hAAA, 1'b1, 1'b1));
    send_req(make_req(3'd6, 12'h800, 3'd3, 12'h555, 1'b1, 1'b1));
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);

    run_phase(0, 0, 460);
    run_phase(57, 0, 460);
    run_phase(0, 57, 460);
    run_phase(21, 21, 460);

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### greedy_graph_coloring.f
hdl/ggc_pkg.sv
hdl/ggc_if.sv
hdl/ggc_ram.sv
hdl/greedy_graph_coloring.sv
tb/ggc_color_checker.sv
tb/tb_greedy_graph_coloring.sv
